FILE: rtl/lge_pkg.sv
// Shared types, constants and helpers for the life generation engine.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none
package lge_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int COL_AW      = $clog2(GRID_WIDTH);
  localparam int ROW_AW      = $clog2(GRID_HEIGHT);
  localparam int COUNT_W     = 4;

  localparam logic [COL_AW-1:0] LAST_COL = COL_AW'(GRID_WIDTH - 2);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_HEIGHT - 2);
  localparam logic [ROW_AW-1:0] TOP_ROW  = ROW_AW'(GRID_HEIGHT - 1);

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] STAY_COUNT  = COUNT_W'(2);

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_in;
  } item_t;

  typedef struct packed {
    logic cell_out;
    logic generation_done;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_WR_WAIT,
    S_ADV_FETCH,
    S_ADV_LAND,
    S_ADV_CELL,
    S_ADV_WRITE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [ROW_AW-1:0]     waddr;
    logic [GRID_WIDTH-1:0] wdata;
    logic [ROW_AW-1:0]     raddr;
  } mem_req_t;

  // True when the item's cell address lies inside the grid.
  function automatic logic in_grid(item_t it);
    return (int'(it.col) < GRID_WIDTH) && (int'(it.row) < GRID_HEIGHT);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lge_grid_mem.sv
// Row-wide grid store: one row written and one row read per cycle.
// Depends on lge_pkg for the grid size and the request struct.
`default_nettype none
module lge_grid_mem (
  input  wire logic                           clk,
  input  wire lge_pkg::mem_req_t              req,
  output logic [lge_pkg::GRID_WIDTH-1:0]      rd_data
);

  logic [lge_pkg::GRID_WIDTH-1:0] mem [lge_pkg::GRID_HEIGHT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/lge_rule_unit.sv
// Neighbour counter and B3/S23 decision for a single cell.
// Depends on lge_pkg for the count width and rule constants.
`default_nettype none
module lge_rule_unit (
  input  wire logic       alive,
  input  wire logic [7:0] neighbours,
  output logic            next_cell
);

  logic [lge_pkg::COUNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + lge_pkg::COUNT_W'(neighbours[i]);
    end
    next_cell = (count == lge_pkg::BIRTH_COUNT) ||
                (alive && (count == lge_pkg::STAY_COUNT));
  end

endmodule
`default_nettype wire

FILE: rtl/life_generation_engine_core.sv
// Top level of the life generation engine: sequencer, line buffer and result register.
// Depends on lge_pkg, lge_grid_mem and lge_rule_unit.
`default_nettype none
// The engine holds a GRID_HEIGHT by GRID_WIDTH grid of cells, stored one row per
// memory word, and takes one item at a time. A read item waits for the registered
// memory read, a write item reads, modifies and writes back a row, and an unused
// kind is answered straight from the idle state. An advance item steps one shared
// rule unit across each interior row one cell per cycle, pausing between rows to
// fetch and write back, and holds the rows above, at and below the current one in
// a three-row line buffer. Border cells keep their stored value. After reset the
// grid is wiped by a clearing pass, one row per cycle, during which no item is
// accepted. Exactly one result item is returned per input item, in order; the next
// item may be accepted while a result still waits in the output register, as long
// as that result is being taken.
module life_generation_engine_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire lge_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output lge_pkg::result_t      result
);

  lge_pkg::state_t state, state_next;
  lge_pkg::item_t  cur, cur_next;
  lge_pkg::mem_req_t req;

  logic [lge_pkg::GRID_WIDTH-1:0] rd_data;
  logic [lge_pkg::GRID_WIDTH-1:0] above, above_next;
  logic [lge_pkg::GRID_WIDTH-1:0] here, here_next;
  logic [lge_pkg::GRID_WIDTH-1:0] below, below_next;
  logic [lge_pkg::GRID_WIDTH-1:0] newrow, newrow_next;
  logic [lge_pkg::GRID_WIDTH-1:0] wrow;

  logic [lge_pkg::ROW_AW-1:0] clr_row, clr_row_next;
  logic [lge_pkg::ROW_AW-1:0] fetch_row, fetch_row_next;
  logic [lge_pkg::ROW_AW-1:0] adv_row, adv_row_next;
  logic [lge_pkg::COL_AW-1:0] col_idx, col_idx_next;

  logic              accept;
  logic              out_load;
  lge_pkg::result_t  out_value;
  logic [7:0]        neighbours;
  logic              cell_next;

  // An item is taken only when the sequencer is idle and the output register
  // is empty or being emptied in this cycle.
  assign item_stall = !((state == lge_pkg::S_IDLE) && (!result_valid || !result_stall));
  assign accept     = item_valid && !item_stall;

  lge_grid_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // The 3x3 window around the current column of the line buffer.
  assign neighbours = {above[col_idx - lge_pkg::COL_AW'(1)], above[col_idx],
                       above[col_idx + lge_pkg::COL_AW'(1)],
                       here[col_idx - lge_pkg::COL_AW'(1)],
                       here[col_idx + lge_pkg::COL_AW'(1)],
                       below[col_idx - lge_pkg::COL_AW'(1)], below[col_idx],
                       below[col_idx + lge_pkg::COL_AW'(1)]};

  lge_rule_unit u_rule (
    .alive      (here[col_idx]),
    .neighbours (neighbours),
    .next_cell  (cell_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lge_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    above_next     = above;
    here_next      = here;
    below_next     = below;
    newrow_next    = newrow;
    clr_row_next   = clr_row;
    fetch_row_next = fetch_row;
    adv_row_next   = adv_row;
    col_idx_next   = col_idx;
    req            = '0;
    out_load       = 1'b0;
    out_value      = '0;
    wrow           = rd_data;

    case (state)
      lge_pkg::S_CLEAR: begin
        // Wipe one row per cycle after reset.
        req.we    = 1'b1;
        req.waddr = clr_row;
        if (clr_row == lge_pkg::TOP_ROW) begin
          state_next = lge_pkg::S_IDLE;
        end else begin
          clr_row_next = clr_row + lge_pkg::ROW_AW'(1);
        end
      end
      lge_pkg::S_IDLE: begin
        if (accept) begin
          cur_next = item;
          req.raddr = lge_pkg::ROW_AW'(item.row);
          case (item.kind)
            lge_pkg::KIND_WRITE: begin
              if (lge_pkg::in_grid(item)) begin
                state_next = lge_pkg::S_WR_WAIT;
              end else begin
                out_load = 1'b1;
              end
            end
            lge_pkg::KIND_READ: begin
              if (lge_pkg::in_grid(item)) begin
                state_next = lge_pkg::S_RD_WAIT;
              end else begin
                out_load = 1'b1;
              end
            end
            lge_pkg::KIND_ADVANCE: begin
              fetch_row_next = '0;
              adv_row_next   = lge_pkg::ROW_AW'(1);
              state_next     = lge_pkg::S_ADV_FETCH;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      lge_pkg::S_RD_WAIT: begin
        out_load           = 1'b1;
        out_value.cell_out = rd_data[lge_pkg::COL_AW'(cur.col)];
        state_next         = lge_pkg::S_IDLE;
      end
      lge_pkg::S_WR_WAIT: begin
        wrow[lge_pkg::COL_AW'(cur.col)] = cur.cell_in;
        req.we     = 1'b1;
        req.waddr  = lge_pkg::ROW_AW'(cur.row);
        req.wdata  = wrow;
        out_load   = 1'b1;
        state_next = lge_pkg::S_IDLE;
      end
      lge_pkg::S_ADV_FETCH: begin
        req.raddr  = fetch_row;
        state_next = lge_pkg::S_ADV_LAND;
      end
      lge_pkg::S_ADV_LAND: begin
        // Slide the line buffer by one row; the new centre row is also the
        // starting image of the row being built, so its border columns stay.
        above_next     = here;
        here_next      = below;
        below_next     = rd_data;
        newrow_next    = below;
        col_idx_next   = lge_pkg::COL_AW'(1);
        fetch_row_next = fetch_row + lge_pkg::ROW_AW'(1);
        if (fetch_row < lge_pkg::ROW_AW'(2)) begin
          state_next = lge_pkg::S_ADV_FETCH;
        end else begin
          state_next = lge_pkg::S_ADV_CELL;
        end
      end
      lge_pkg::S_ADV_CELL: begin
        newrow_next[col_idx] = cell_next;
        if (col_idx == lge_pkg::LAST_COL) begin
          state_next = lge_pkg::S_ADV_WRITE;
        end else begin
          col_idx_next = col_idx + lge_pkg::COL_AW'(1);
        end
      end
      lge_pkg::S_ADV_WRITE: begin
        req.we    = 1'b1;
        req.waddr = adv_row;
        req.wdata = newrow;
        if (adv_row == lge_pkg::LAST_ROW) begin
          out_load                  = 1'b1;
          out_value.generation_done = 1'b1;
          state_next                = lge_pkg::S_IDLE;
        end else begin
          adv_row_next = adv_row + lge_pkg::ROW_AW'(1);
          state_next   = lge_pkg::S_ADV_FETCH;
        end
      end
      default: begin
        state_next = lge_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row      <= '0;
      result_valid <= 1'b0;
    end else begin
      clr_row <= clr_row_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    above     <= above_next;
    here      <= here_next;
    below     <= below_next;
    newrow    <= newrow_next;
    fetch_row <= fetch_row_next;
    adv_row   <= adv_row_next;
    col_idx   <= col_idx_next;
    if (out_load) begin
      result <= out_value;
    end
  end

  // A new result never overwrites one that is still waiting to be taken.
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

  // The rule unit only ever works on interior columns.
  assert property (@(posedge clk) disable iff (rst)
    (state == lge_pkg::S_ADV_CELL) |->
      (col_idx >= lge_pkg::COL_AW'(1)) && (col_idx <= lge_pkg::LAST_COL))
    else $error("advance column outside the interior");

  // Only interior rows are written back by an advance.
  assert property (@(posedge clk) disable iff (rst)
    (state == lge_pkg::S_ADV_WRITE) |->
      (adv_row >= lge_pkg::ROW_AW'(1)) && (adv_row <= lge_pkg::LAST_ROW))
    else $error("advance row outside the interior");

  // A completed generation never carries a cell value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.cell_out && result.generation_done))
    else $error("result carries both a cell and a generation flag");

endmodule
`default_nettype wire
